/* src/htfd_pkg.sv */
// Shared types, constants and the CRC-8 step for the humidity/temperature frame decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package htfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned TEMP_W   = 15;
	localparam int unsigned HUM_W    = 14;
	localparam int unsigned STATUS_W = 2;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

	// Conversion constants: temperature ((4375*raw)>>14)-4500, humidity (625*raw)>>12
	localparam int unsigned TEMP_MUL   = 4375;
	localparam int unsigned TEMP_SHIFT = 14;
	localparam int unsigned TEMP_OFS   = 4500;
	localparam int unsigned HUM_MUL    = 625;
	localparam int unsigned HUM_SHIFT  = 12;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_centi;
		logic [HUM_W-1:0]         humidity_centi;
		status_t                  frame_status;
	} result_t;

	// One byte through CRC-8, MSB first.
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if ((c & CRC_TOP) != '0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* src/htfd_in_stage.sv */
// Input register of the frame decoder: holds one accepted byte beat until the core takes it.
// Depends on htfd_pkg for widths.
`default_nettype none

module htfd_in_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [htfd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                        frame_start,
	input  wire logic                        take,
	output logic                             valid_s1,
	output logic [htfd_pkg::BYTE_W-1:0]      byte_s1,
	output logic                             start_s1
);
	import htfd_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

endmodule

`default_nettype wire

/* src/htfd_frame_core.sv */
// Frame state, CRC check and unit conversion of the decoder, one byte per cycle unless a result byte is held.
// Depends on htfd_pkg for types, constants and the CRC step.
`default_nettype none

module htfd_frame_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s1,
	input  wire logic [htfd_pkg::BYTE_W-1:0] byte_s1,
	input  wire logic                        start_s1,
	input  wire logic                        take,
	output logic                             res_need,
	output htfd_pkg::result_t                res
);
	import htfd_pkg::*;

	localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
	localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
	localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
	localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
	localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
	localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;
	localparam logic [POS_W-1:0] POS_DONE  = 3'd6;

	localparam int unsigned TPROD_W = WORD_W + 13;
	localparam int unsigned HPROD_W = WORD_W + 10;

	logic [POS_W-1:0]         pos_q;
	logic [BYTE_W-1:0]        crc_q;
	logic [WORD_W-1:0]        word_q;
	logic [WORD_W-1:0]        temp_raw_q;
	logic                     temp_fail_q;
	logic signed [TEMP_W-1:0] kept_temp_q;
	logic [HUM_W-1:0]         kept_hum_q;

	logic [POS_W-1:0]         pos_eff;
	logic [BYTE_W-1:0]        crc_eff;
	logic [BYTE_W-1:0]        crc_next;
	logic [TPROD_W-1:0]       temp_prod;
	logic [HPROD_W-1:0]       hum_prod;
	logic signed [TEMP_W-1:0] temp_conv;
	logic [HUM_W-1:0]         hum_conv;
	status_t                  status;

	// A start mark restarts the position and the CRC before this byte is used
	assign pos_eff  = start_s1 ? POS_T_HI : pos_q;
	assign crc_eff  = start_s1 ? CRC_INIT : crc_q;
	assign crc_next = crc8_update(crc_eff, byte_s1);

	assign temp_prod = TPROD_W'(temp_raw_q) * TPROD_W'(TEMP_MUL);
	assign hum_prod  = HPROD_W'(word_q) * HPROD_W'(HUM_MUL);
	assign temp_conv = TEMP_W'(temp_prod[TPROD_W-1:TEMP_SHIFT]) - TEMP_W'(TEMP_OFS);
	assign hum_conv  = hum_prod[HPROD_W-1:HUM_SHIFT];

	always_comb begin
		if (temp_fail_q) begin
			status = STATUS_TEMP_CRC;
		end else if (byte_s1 != crc_eff) begin
			status = STATUS_HUM_CRC;
		end else begin
			status = STATUS_OK;
		end
	end

	assign res_need = valid_s1 && (pos_eff == POS_H_CRC);

	always_comb begin
		res.frame_status = status;
		if (status == STATUS_OK) begin
			res.temperature_centi = temp_conv;
			res.humidity_centi    = hum_conv;
		end else begin
			res.temperature_centi = kept_temp_q;
			res.humidity_centi    = kept_hum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_T_HI;
			crc_q       <= CRC_INIT;
			word_q      <= '0;
			temp_fail_q <= 1'b0;
			kept_temp_q <= '0;
			kept_hum_q  <= '0;
		end else if (take) begin
			unique case (pos_eff)
				POS_T_HI, POS_H_HI: begin
					word_q <= {byte_s1, BYTE_W'(0)};
					crc_q  <= crc_next;
					pos_q  <= pos_eff + 3'd1;
				end
				POS_T_LO, POS_H_LO: begin
					word_q <= {word_q[WORD_W-1:BYTE_W], byte_s1};
					crc_q  <= crc_next;
					pos_q  <= pos_eff + 3'd1;
				end
				POS_T_CRC: begin
					temp_fail_q <= (byte_s1 != crc_eff);
					crc_q       <= CRC_INIT;
					pos_q       <= POS_H_HI;
				end
				POS_H_CRC: begin
					if (status == STATUS_OK) begin
						kept_temp_q <= temp_conv;
						kept_hum_q  <= hum_conv;
					end
					crc_q <= CRC_INIT;
					pos_q <= POS_DONE;
				end
				default: begin
					// Drop bytes past the frame; a start mark still resets the CRC
					crc_q <= crc_eff;
					pos_q <= pos_eff;
				end
			endcase
		end
	end

	// Raw temperature is always written before it is read
	always_ff @(posedge clk) begin
		if (take && pos_eff == POS_T_CRC) begin
			temp_raw_q <= word_q;
		end
	end

endmodule

`default_nettype wire

/* src/htfd_out_stage.sv */
// Result register of the frame decoder: holds one result beat until the receiver takes it.
// Depends on htfd_pkg for the result type.
`default_nettype none

module htfd_out_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire htfd_pkg::result_t      res,
	output logic                        out_free,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [htfd_pkg::TEMP_W-1:0]   temperature_centi,
	output logic [htfd_pkg::HUM_W-1:0]           humidity_centi,
	output logic [htfd_pkg::STATUS_W-1:0]        frame_status
);
	import htfd_pkg::*;

	result_t res_q;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign temperature_centi = res_q.temperature_centi;
	assign humidity_centi    = res_q.humidity_centi;
	assign frame_status      = res_q.frame_status;

endmodule

`default_nettype wire

/* src/humidity_temperature_frame_decoder_top.sv */
// Humidity/temperature frame decoder, top level: input register, frame core, result register.
// Depends on htfd_pkg, htfd_in_stage, htfd_frame_core and htfd_out_stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per beat: rx_byte and
//   frame_start, which marks byte 0 of a new frame and restarts the byte position.
//   A frame is temperature high, low, CRC, humidity high, low, CRC; each CRC is
//   CRC-8, polynomial 0x31, init 0xFF over its word's two bytes.
//   Output channel (out_valid/out_ready) gives one result beat per complete frame,
//   on the sixth byte: temperature_centi (signed, 0.01 degC), humidity_centi
//   (0.01 %RH) and frame_status (ok, temperature CRC bad, humidity CRC bad).
//   A bad frame repeats the last good values; bytes past the sixth are dropped
//   until the next start mark.
//   Path: a frame's sixth byte is accepted into the input register, and its result
//   is then loaded from there into the result register; a stall holds the byte in
//   the input register.
//   Throughput: one byte per cycle unless a result byte stalls; the CRC step and both
//   constant multiplies sit between the input register and the state/result registers.
//   Stall: when the result register is full and not taken, only a byte that makes
//   a result waits; the input register then fills and in_ready drops.
//   Reset (arst_n low): position 0, CRC 0xFF, kept values zero, both channels empty.
`default_nettype none

module humidity_temperature_frame_decoder_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [htfd_pkg::BYTE_W-1:0]         rx_byte,
	input  wire logic                                frame_start,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [htfd_pkg::TEMP_W-1:0]       temperature_centi,
	output logic [htfd_pkg::HUM_W-1:0]               humidity_centi,
	output logic [htfd_pkg::STATUS_W-1:0]            frame_status
);
	import htfd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic              take;
	logic              res_need;
	logic              out_free;
	result_t           res;

	// Advance the held byte unless it makes a result and the result register is stalled
	assign take = valid_s1 && (!res_need || out_free);

	htfd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.take       (take),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.start_s1   (start_s1)
	);

	htfd_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.byte_s1 (byte_s1),
		.start_s1(start_s1),
		.take    (take),
		.res_need(res_need),
		.res     (res)
	);

	htfd_out_stage u_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (take && res_need),
		.res              (res),
		.out_free         (out_free),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.temperature_centi(temperature_centi),
		.humidity_centi   (humidity_centi),
		.frame_status     (frame_status)
	);

endmodule

`default_nettype wire

/* src/htfd_checker.sv */
// Port-level checks for the frame decoder, bound to the top level.
// Depends on htfd_pkg for widths and status codes.
`default_nettype none

module htfd_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic [htfd_pkg::BYTE_W-1:0]         rx_byte,
	input wire logic                                frame_start,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [htfd_pkg::TEMP_W-1:0]  temperature_centi,
	input wire logic [htfd_pkg::HUM_W-1:0]          humidity_centi,
	input wire logic [htfd_pkg::STATUS_W-1:0]       frame_status
);
	import htfd_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_status)
			&& $stable(temperature_centi) && $stable(humidity_centi))
		else $error("result beat changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status == STATUS_OK || frame_status == STATUS_TEMP_CRC
			|| frame_status == STATUS_HUM_CRC))
		else $error("undefined frame status");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_centi <= HUM_W'(9999))
		else $error("humidity out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi >= -TEMP_W'(4500))
		else $error("temperature out of range");

endmodule

bind humidity_temperature_frame_decoder_top htfd_checker u_htfd_checker (.*);

`default_nettype wire
